// ===== hdl/fte_pkg.sv =====
`timescale 1ns / 1ps

package fte_pkg;

  // Table store geometry
  localparam int TABLE_BYTES = 8192;
  localparam int RAM_AW      = $clog2(TABLE_BYTES);
  // Byte offsets of entries reach 3 * 4095 + 2, which needs 14 bits
  localparam int BYTE_AW     = 14;

  // Field widths
  localparam int KIND_W = 3;
  localparam int IDX_W  = 13;
  localparam int ENT_W  = 12;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 13;
  localparam int BYTE_W = 8;

  // Special entry values
  localparam logic [ENT_W-1:0] ENT_FREE = 12'h000;
  localparam logic [ENT_W-1:0] ENT_END  = 12'hFFF;
  localparam logic [IDX_W-1:0] END_IDX  = IDX_W'(ENT_END);

  // Free search bounds
  localparam logic [CFG_W-1:0] SCAN_CAP       = 13'd4096;
  localparam logic [CFG_W-1:0] SCAN_LIMIT_RST = 13'd1536;
  localparam logic [IDX_W-1:0] SCAN_FIRST     = 13'd2;

  // Command kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_RD_ENT     = 3'd0,
    KIND_WR_ENT     = 3'd1,
    KIND_FIND_FREE  = 3'd2,
    KIND_LOAD_BYTE  = 3'd3,
    KIND_RD_BYTE    = 3'd4,
    KIND_RESIZE     = 3'd5
  } kind_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_RESERVED = 2'd1,
    ST_NO_FREE  = 2'd2
  } status_t;

  // Access unit operations
  typedef enum logic [1:0] {
    ACC_RD_ENT  = 2'd0,
    ACC_WR_ENT  = 2'd1,
    ACC_RD_BYTE = 2'd2,
    ACC_WR_BYTE = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic             valid;
    acc_op_t          op;
    logic [IDX_W-1:0] index;
    logic [ENT_W-1:0] value;
  } acc_req_t;

  typedef struct packed {
    logic             done;
    logic [ENT_W-1:0] data;
  } acc_rsp_t;

  // Entries 0, 1 and 0xFFF are never touched by entry accesses
  function automatic logic is_reserved(input logic [IDX_W-1:0] e);
    return (e < IDX_W'(2)) || (e == END_IDX);
  endfunction

endpackage

// ===== hdl/fte_in_if.sv =====
`timescale 1ns / 1ps

interface fte_in_if;
  logic                       valid;
  logic                       ready;
  logic [fte_pkg::KIND_W-1:0] kind;
  logic [fte_pkg::IDX_W-1:0]  index;
  logic [fte_pkg::ENT_W-1:0]  value;

  modport source (output valid, output kind, output index, output value, input ready);
  modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

// ===== hdl/fte_out_if.sv =====
`timescale 1ns / 1ps

interface fte_out_if;
  logic                       valid;
  logic                       ready;
  logic [fte_pkg::ENT_W-1:0]  read_data;
  logic [fte_pkg::STAT_W-1:0] status;

  modport source (output valid, output read_data, output status, input ready);
  modport sink   (input valid, input read_data, input status, output ready);
endinterface

// ===== hdl/fat12_table_engine_top.sv =====
`timescale 1ns / 1ps
// Find free scans entries from 2 upward; resize chain walks the chain link by link
// and runs a free scan from entry 2 for each link it adds.
// One command at a time; the next can be taken in the cycle after its result is registered.
// Reset clears control state and sets scan_limit to 1536; the table is not cleared.
module fat12_table_engine_top (
  input  logic                      clk,
  input  logic                      rst,
  fte_in_if.sink                    cmd,
  fte_out_if.source                 res,
  input  logic                      cfg_wr_en,
  input  logic [fte_pkg::CFG_W-1:0] cfg_wr_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ACC_WAIT,
    S_FF_CHECK,
    S_FF_WAIT,
    S_RZ_LOOP,
    S_RZ_NEXT,
    S_RZ_ACT,
    S_RZ_CLAIM,
    S_RZ_END_WAIT,
    S_RZ_LINK,
    S_RZ_WWAIT,
    S_RZ_ADV,
    S_PUT
  } seq_state_t;

  seq_state_t                   state;
  logic [fte_pkg::KIND_W-1:0]   kind;
  logic [fte_pkg::IDX_W-1:0]    idx;
  logic [fte_pkg::ENT_W-1:0]    val;
  logic [fte_pkg::CFG_W-1:0]    scan_limit;
  logic [fte_pkg::IDX_W-1:0]    scan_idx;
  logic [fte_pkg::IDX_W-1:0]    cl;
  logic [fte_pkg::IDX_W-1:0]    nxt;
  logic [fte_pkg::IDX_W-1:0]    prev;
  logic [fte_pkg::IDX_W-1:0]    start;
  logic [fte_pkg::ENT_W-1:0]    rem_cnt;
  logic                         rem_neg;
  logic                         in_resize;
  logic [fte_pkg::ENT_W-1:0]    res_data;
  fte_pkg::status_t             res_status;
  logic                         out_valid;
  logic [fte_pkg::ENT_W-1:0]    out_data;
  fte_pkg::status_t             out_status;

  fte_pkg::acc_req_t            acc_req;
  fte_pkg::acc_rsp_t            acc_rsp;

  logic [fte_pkg::CFG_W-1:0]    lim;
  logic                         cl_end;
  logic                         rem_pos;
  logic                         rem_zero;
  logic                         loop_go;
  logic                         byte_oob;

  assign lim      = (scan_limit > fte_pkg::SCAN_CAP) ? fte_pkg::SCAN_CAP : scan_limit;
  assign cl_end   = (cl == fte_pkg::END_IDX);
  assign rem_pos  = !rem_neg && (rem_cnt != '0);
  assign rem_zero = !rem_neg && (rem_cnt == '0);
  assign loop_go  = !cl_end || !rem_neg;
  assign byte_oob = fte_pkg::BYTE_AW'(idx) >= fte_pkg::BYTE_AW'(fte_pkg::TABLE_BYTES);

  assign cmd.ready     = (state == S_IDLE);
  assign res.valid     = out_valid;
  assign res.read_data = out_data;
  assign res.status    = out_status;

  // Issue table accesses from the sequencer states
  always_comb begin
    acc_req.valid = 1'b0;
    acc_req.op    = fte_pkg::ACC_RD_ENT;
    acc_req.index = idx;
    acc_req.value = val;
    case (state)
      S_DISPATCH: begin
        case (kind)
          fte_pkg::KIND_RD_ENT: begin
            acc_req.valid = 1'b1;
          end
          fte_pkg::KIND_WR_ENT: begin
            acc_req.valid = 1'b1;
            acc_req.op    = fte_pkg::ACC_WR_ENT;
          end
          fte_pkg::KIND_LOAD_BYTE: begin
            acc_req.valid = !byte_oob;
            acc_req.op    = fte_pkg::ACC_WR_BYTE;
          end
          fte_pkg::KIND_RD_BYTE: begin
            acc_req.valid = !byte_oob;
            acc_req.op    = fte_pkg::ACC_RD_BYTE;
          end
          default: begin
          end
        endcase
      end
      S_FF_CHECK: begin
        acc_req.valid = (fte_pkg::CFG_W'(scan_idx) < lim);
        acc_req.index = scan_idx;
      end
      S_RZ_LOOP: begin
        acc_req.valid = loop_go && !cl_end;
        acc_req.index = cl;
      end
      S_RZ_ACT: begin
        acc_req.valid = !cl_end && (rem_zero || rem_neg);
        acc_req.op    = fte_pkg::ACC_WR_ENT;
        acc_req.index = cl;
        acc_req.value = rem_neg ? fte_pkg::ENT_FREE : fte_pkg::ENT_END;
      end
      S_RZ_CLAIM: begin
        acc_req.valid = 1'b1;
        acc_req.op    = fte_pkg::ACC_WR_ENT;
        acc_req.index = cl;
        acc_req.value = fte_pkg::ENT_END;
      end
      S_RZ_LINK: begin
        acc_req.valid = 1'b1;
        acc_req.op    = fte_pkg::ACC_WR_ENT;
        acc_req.index = prev;
        acc_req.value = cl[fte_pkg::ENT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Command sequencer, scan limit register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      scan_limit <= fte_pkg::SCAN_LIMIT_RST;
    end else begin
      if (cfg_wr_en) begin
        scan_limit <= cfg_wr_data;
      end
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            kind  <= cmd.kind;
            idx   <= cmd.index;
            val   <= cmd.value;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_data <= '0;
          case (kind)
            fte_pkg::KIND_RD_ENT, fte_pkg::KIND_WR_ENT: begin
              res_status <= fte_pkg::is_reserved(idx) ? fte_pkg::ST_RESERVED : fte_pkg::ST_OK;
              state      <= S_ACC_WAIT;
            end
            fte_pkg::KIND_LOAD_BYTE, fte_pkg::KIND_RD_BYTE: begin
              res_status <= byte_oob ? fte_pkg::ST_RESERVED : fte_pkg::ST_OK;
              state      <= byte_oob ? S_PUT : S_ACC_WAIT;
            end
            fte_pkg::KIND_FIND_FREE: begin
              in_resize <= 1'b0;
              scan_idx  <= fte_pkg::SCAN_FIRST;
              state     <= S_FF_CHECK;
            end
            fte_pkg::KIND_RESIZE: begin
              cl      <= idx;
              rem_cnt <= val;
              rem_neg <= 1'b0;
              prev    <= '0;
              start   <= fte_pkg::END_IDX;
              state   <= S_RZ_LOOP;
            end
            default: begin
              res_status <= fte_pkg::ST_RESERVED;
              state      <= S_PUT;
            end
          endcase
        end
        S_ACC_WAIT: begin
          if (acc_rsp.done) begin
            res_data <= (kind == fte_pkg::KIND_RD_ENT || kind == fte_pkg::KIND_RD_BYTE) ?
                        acc_rsp.data : '0;
            state    <= S_PUT;
          end
        end
        S_FF_CHECK: begin
          if (fte_pkg::CFG_W'(scan_idx) < lim) begin
            state <= S_FF_WAIT;
          end else begin
            // No free entry: a resize keeps its partial work
            res_data   <= in_resize ? start[fte_pkg::ENT_W-1:0] : '0;
            res_status <= fte_pkg::ST_NO_FREE;
            state      <= S_PUT;
          end
        end
        S_FF_WAIT: begin
          if (acc_rsp.done) begin
            if (acc_rsp.data == fte_pkg::ENT_FREE) begin
              if (in_resize) begin
                cl    <= scan_idx;
                state <= S_RZ_CLAIM;
              end else begin
                res_data   <= scan_idx[fte_pkg::ENT_W-1:0];
                res_status <= fte_pkg::ST_OK;
                state      <= S_PUT;
              end
            end else begin
              scan_idx <= scan_idx + 1'b1;
              state    <= S_FF_CHECK;
            end
          end
        end
        S_RZ_LOOP: begin
          if (!loop_go) begin
            res_data   <= start[fte_pkg::ENT_W-1:0];
            res_status <= (start == fte_pkg::END_IDX) ? fte_pkg::ST_RESERVED : fte_pkg::ST_OK;
            state      <= S_PUT;
          end else if (cl_end) begin
            nxt   <= fte_pkg::END_IDX;
            state <= S_RZ_ACT;
          end else begin
            state <= S_RZ_NEXT;
          end
        end
        S_RZ_NEXT: begin
          if (acc_rsp.done) begin
            nxt   <= fte_pkg::IDX_W'(acc_rsp.data);
            state <= S_RZ_ACT;
          end
        end
        S_RZ_ACT: begin
          if (rem_pos && cl_end) begin
            // Extend the chain from the first free entry
            in_resize <= 1'b1;
            scan_idx  <= fte_pkg::SCAN_FIRST;
            state     <= S_FF_CHECK;
          end else if (!cl_end && (rem_zero || rem_neg)) begin
            state <= S_RZ_WWAIT;
          end else begin
            state <= S_RZ_ADV;
          end
        end
        S_RZ_CLAIM: begin
          state <= S_RZ_END_WAIT;
        end
        S_RZ_END_WAIT: begin
          if (acc_rsp.done) begin
            state <= S_RZ_LINK;
          end
        end
        S_RZ_LINK: begin
          state <= S_RZ_WWAIT;
        end
        S_RZ_WWAIT: begin
          if (acc_rsp.done) begin
            state <= S_RZ_ADV;
          end
        end
        S_RZ_ADV: begin
          if (start == fte_pkg::END_IDX) begin
            start <= cl;
          end
          prev <= cl;
          cl   <= nxt;
          if (!rem_neg) begin
            if (rem_cnt == '0) begin
              rem_neg <= 1'b1;
            end else begin
              rem_cnt <= rem_cnt - 1'b1;
            end
          end
          state <= S_RZ_LOOP;
        end
        S_PUT: begin
          // Hold until the result register is free
          if (!out_valid || res.ready) begin
            out_valid  <= 1'b1;
            out_data   <= res_data;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  fte_access u_access (
    .clk (clk),
    .rst (rst),
    .req (acc_req),
    .rsp (acc_rsp)
  );

endmodule

// ===== hdl/fte_ram.sv =====
`timescale 1ns / 1ps

module fte_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fte_access.sv =====
`timescale 1ns / 1ps

module fte_access (
  input  logic              clk,
  input  logic              rst,
  input  fte_pkg::acc_req_t req,
  output fte_pkg::acc_rsp_t rsp
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_ISSUE,
    A_RD_HI,
    A_RD_FIN,
    A_RB_FIN,
    A_WR_MID
  } acc_state_t;

  acc_state_t                   state;
  fte_pkg::acc_op_t             op;
  logic [fte_pkg::IDX_W-1:0]    idx;
  logic [fte_pkg::ENT_W-1:0]    val;
  logic [fte_pkg::BYTE_W-1:0]   lo_byte;

  logic                         ram_we;
  logic [fte_pkg::RAM_AW-1:0]   ram_waddr;
  logic [fte_pkg::BYTE_W-1:0]   ram_wdata;
  logic [fte_pkg::RAM_AW-1:0]   ram_raddr;
  logic [fte_pkg::BYTE_W-1:0]   ram_rdata;

  logic [fte_pkg::IDX_W-2:0]    half;
  logic [fte_pkg::BYTE_AW-1:0]  off;
  logic [fte_pkg::BYTE_AW-1:0]  addr_lo;
  logic [fte_pkg::BYTE_AW-1:0]  addr_hi;
  logic [fte_pkg::BYTE_AW-1:0]  addr_full;
  logic [fte_pkg::BYTE_AW-1:0]  addr_mid;
  logic [fte_pkg::BYTE_AW-1:0]  addr_byte;
  logic                         odd;
  logic                         rsvd;
  logic [fte_pkg::BYTE_W-1:0]   hi_byte;
  logic [fte_pkg::BYTE_W-1:0]   merged;

  function automatic logic in_range(input logic [fte_pkg::BYTE_AW-1:0] a);
    return a < fte_pkg::BYTE_AW'(fte_pkg::TABLE_BYTES);
  endfunction

  // Byte addresses of the latched entry: entry pair k starts at byte 3k
  assign half      = idx[fte_pkg::IDX_W-1:1];
  assign odd       = idx[0];
  assign off       = fte_pkg::BYTE_AW'({half, 1'b0}) + fte_pkg::BYTE_AW'(half);
  assign addr_mid  = off + fte_pkg::BYTE_AW'(1);
  assign addr_full = odd ? off + fte_pkg::BYTE_AW'(2) : off;
  assign addr_lo   = odd ? addr_mid : off;
  assign addr_hi   = odd ? off + fte_pkg::BYTE_AW'(2) : addr_mid;
  assign addr_byte = fte_pkg::BYTE_AW'(idx);
  assign rsvd      = fte_pkg::is_reserved(idx);

  assign hi_byte = in_range(addr_hi) ? ram_rdata : '0;
  // Merge the new nibble into the shared middle byte
  assign merged  = odd ? {val[3:0], ram_rdata[3:0]} : {ram_rdata[7:4], val[11:8]};

  // Drive the store port and the response
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_full[fte_pkg::RAM_AW-1:0];
    ram_wdata = odd ? val[11:4] : val[7:0];
    ram_raddr = addr_lo[fte_pkg::RAM_AW-1:0];
    rsp.done  = 1'b0;
    rsp.data  = '0;
    case (state)
      A_ISSUE: begin
        case (op)
          fte_pkg::ACC_RD_ENT: begin
            if (rsvd) begin
              rsp.done = 1'b1;
              rsp.data = fte_pkg::ENT_END;
            end
          end
          fte_pkg::ACC_WR_ENT: begin
            ram_raddr = addr_mid[fte_pkg::RAM_AW-1:0];
            ram_we    = !rsvd && in_range(addr_full);
            rsp.done  = rsvd;
          end
          fte_pkg::ACC_RD_BYTE: begin
            ram_raddr = addr_byte[fte_pkg::RAM_AW-1:0];
          end
          fte_pkg::ACC_WR_BYTE: begin
            ram_waddr = addr_byte[fte_pkg::RAM_AW-1:0];
            ram_wdata = val[7:0];
            ram_we    = in_range(addr_byte);
            rsp.done  = 1'b1;
          end
          default: begin
          end
        endcase
      end
      A_RD_HI: begin
        ram_raddr = addr_hi[fte_pkg::RAM_AW-1:0];
      end
      A_RD_FIN: begin
        rsp.done = 1'b1;
        rsp.data = odd ? {hi_byte, lo_byte[7:4]} : {hi_byte[3:0], lo_byte};
      end
      A_RB_FIN: begin
        rsp.done = 1'b1;
        rsp.data = in_range(addr_byte) ? fte_pkg::ENT_W'(ram_rdata) : '0;
      end
      A_WR_MID: begin
        ram_waddr = addr_mid[fte_pkg::RAM_AW-1:0];
        ram_wdata = merged;
        ram_we    = in_range(addr_mid);
        rsp.done  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequence the byte accesses of one operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: begin
          if (req.valid) begin
            op    <= req.op;
            idx   <= req.index;
            val   <= req.value;
            state <= A_ISSUE;
          end
        end
        A_ISSUE: begin
          case (op)
            fte_pkg::ACC_RD_ENT:  state <= rsvd ? A_IDLE : A_RD_HI;
            fte_pkg::ACC_WR_ENT:  state <= rsvd ? A_IDLE : A_WR_MID;
            fte_pkg::ACC_RD_BYTE: state <= A_RB_FIN;
            default:              state <= A_IDLE;
          endcase
        end
        A_RD_HI: begin
          lo_byte <= in_range(addr_lo) ? ram_rdata : '0;
          state   <= A_RD_FIN;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  fte_ram #(
    .DATA_W (fte_pkg::BYTE_W),
    .DEPTH  (fte_pkg::TABLE_BYTES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== hdl/fte_checker.sv =====
`timescale 1ns / 1ps

module fte_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [fte_pkg::ENT_W-1:0]  res_read_data,
  input logic [fte_pkg::STAT_W-1:0] res_status
);

  // A stalled result holds its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_read_data) && $stable(res_status))
    else $error("result changed while stalled");

  // The engine works on one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  // Status code three is never produced
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_status != 2'd3)
    else $error("undefined status code");

  // Ignored or empty results carry zero or the end marker
  a_reserved_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == fte_pkg::ST_RESERVED |->
      res_read_data == fte_pkg::ENT_FREE || res_read_data == fte_pkg::ENT_END)
    else $error("reserved status with unexpected data");

  // No result is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid after reset");

endmodule

bind fat12_table_engine_top fte_checker u_fte_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_read_data (res.read_data),
  .res_status    (res.status)
);
